### design/splc_pkg.sv
`default_nettype none
package splc_pkg;

   // Control point storage
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 7;
   localparam int NCH        = 3;

   // Shared divider widths: dividend and pre-shifted divisor
   localparam int DIV_NW = 41;
   localparam int DIV_DW = DIV_NW + 7;

   // One control point position, all three channels
   typedef struct packed {
      logic [NCH-1:0][15:0] level;
      logic [NCH-1:0][15:0] bright;
   } pt_type;

endpackage
`default_nettype wire

### design/splc_cell.sv
`default_nettype none
module splc_cell (
   input  wire logic               clock,
   input  wire logic               shift_en,
   input  wire logic               load_en,
   input  wire logic [1:0]         load_ch,
   input  wire logic [15:0]        load_level,
   input  wire logic [15:0]        load_bright,
   input  wire splc_pkg::pt_type   nxt,
   output      splc_pkg::pt_type   pt
);
   import splc_pkg::*;

   pt_type pt_ff;
   pt_type pt_in;

   // Rotate along the ring, or take a loaded point
   always_comb begin
      pt_in = pt_ff;
      if (shift_en) begin
         pt_in = nxt;
      end else if (load_en) begin
         case (load_ch)
            2'd0: begin
               pt_in.level[0]  = load_level;
               pt_in.bright[0] = load_bright;
            end
            2'd1: begin
               pt_in.level[1]  = load_level;
               pt_in.bright[1] = load_bright;
            end
            2'd2: begin
               pt_in.level[2]  = load_level;
               pt_in.bright[2] = load_bright;
            end
            default: begin
               pt_in = pt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule
`default_nettype wire

### design/splc_div8.sv
`default_nettype none
module splc_div8 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [splc_pkg::DIV_NW-1:0] num,
   input  wire logic [splc_pkg::DIV_NW-1:0] den,
   output      logic                        done,
   output      logic [7:0]                  quot
);
   import splc_pkg::*;

   logic [DIV_NW-1:0] rem_ff;
   logic [DIV_DW-1:0] dsh_ff;
   logic [7:0]        q_ff;
   logic [2:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              ge;

   // Trial subtract of the shifted divisor
   assign ge = ({7'd0, rem_ff} >= dsh_ff);

   // Control: one quotient bit per cycle, eight quotient bits in all
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder, divisor and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= {den, 7'd0};
         q_ff   <= 8'd0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff[DIV_NW-1:0];
         end
         q_ff   <= {q_ff[6:0], ge};
         dsh_ff <= {1'b0, dsh_ff[DIV_DW-1:1]};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

### design/scaled_piecewise_linear_colormap_top.sv
`default_nettype none
// Channel   Direction  Handshake                        Payload
// req       in         req_valid / req_stall            cmd channel point_index level
//                                                       brightness sample
// rsp       out        rsp_valid / rsp_stall            gray red green blue
// csr       in         psel penable pwrite pready       paddr pwdata prdata
//
// A load transfer writes straight into the control point ring. A pixel holds the input from
// the transfer on: the gray level is scaled (setup, then the shared divider when needed),
// the control point ring makes one full turn past its head cell, each channel goes through
// multiply, sum and, when needed, the shared 8-step divider, and the result is moved out.
// Synchronous reset clears control state and sets the configuration registers to defaults.
// One pixel is worked at a time; a new transfer is taken while a result waits on
// rsp_stall, and the finished result holds until the output register is free.
module scaled_piecewise_linear_colormap_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_cmd,
   input  wire logic [1:0]  req_channel,
   input  wire logic [5:0]  req_point_index,
   input  wire logic [15:0] req_level,
   input  wire logic [15:0] req_brightness,
   input  wire logic [31:0] req_sample,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_gray,
   output      logic [7:0]  rsp_red,
   output      logic [7:0]  rsp_green,
   output      logic [7:0]  rsp_blue,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   import splc_pkg::*;

   localparam logic [2:0] REG_BLACK  = 3'd0;
   localparam logic [2:0] REG_WHITE  = 3'd1;
   localparam logic [2:0] REG_RED    = 3'd2;
   localparam logic [2:0] REG_GREEN  = 3'd3;
   localparam logic [2:0] REG_BLUE   = 3'd4;
   localparam logic [2:0] REG_INVERT = 3'd5;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_GPRE = 8'b0000_0010,
      ST_GDIV = 8'b0000_0100,
      ST_SCAN = 8'b0000_1000,
      ST_MUL  = 8'b0001_0000,
      ST_SUM  = 8'b0010_0000,
      ST_CDIV = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   // Configuration registers
   logic [31:0]                black_ff;
   logic [31:0]                white_ff;
   logic [NCH-1:0][CNT_W-1:0]  cnt_ff;
   logic                       invert_ff;
   logic                       csr_wr;
   logic [2:0]                 csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff  <= 32'd65536;
         white_ff  <= 32'd131072;
         cnt_ff    <= {NCH{7'd2}};
         invert_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BLACK:  black_ff  <= pwdata;
            REG_WHITE:  white_ff  <= pwdata;
            REG_RED:    cnt_ff[0] <= pwdata[CNT_W-1:0];
            REG_GREEN:  cnt_ff[1] <= pwdata[CNT_W-1:0];
            REG_BLUE:   cnt_ff[2] <= pwdata[CNT_W-1:0];
            REG_INVERT: invert_ff <= pwdata[0];
            default:    ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_idx)
         REG_BLACK:  prdata = black_ff;
         REG_WHITE:  prdata = white_ff;
         REG_RED:    prdata = {25'd0, cnt_ff[0]};
         REG_GREEN:  prdata = {25'd0, cnt_ff[1]};
         REG_BLUE:   prdata = {25'd0, cnt_ff[2]};
         REG_INVERT: prdata = {31'd0, invert_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // Control state
   state_type state_ff, state_in;
   logic             req_take;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] k_ff;
   logic [1:0]       ch_ff;
   logic             load_go;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign load_go   = req_take & (req_cmd == CMD_LOAD) & (req_channel != 2'd3);

   // Control point ring: cell i takes cell i+1, last takes the head
   pt_type cell_pt [MAX_POINTS];
   logic   ring_shift;

   assign ring_shift = (state_ff == ST_SCAN);

   for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
      splc_cell u_cell (
         .clock       (clock),
         .shift_en    (ring_shift),
         .load_en     (load_go && (req_point_index == IDX_W'(gi))),
         .load_ch     (req_channel),
         .load_level  (req_level),
         .load_bright (req_brightness),
         .nxt         (cell_pt[(gi + 1) % MAX_POINTS]),
         .pt          (cell_pt[gi])
      );
   end

   // Sample and gray
   logic [31:0] sample_ff;
   logic [7:0]  gray_ff;
   logic [32:0] w_s, d_s;
   logic        w_pos, d_pos, d_ge_w;

   always_comb begin
      w_s    = {white_ff[31], white_ff} - {black_ff[31], black_ff};
      d_s    = {sample_ff[31], sample_ff} - {black_ff[31], black_ff};
      w_pos  = ~w_s[32] & (w_s != 33'd0);
      d_pos  = ~d_s[32] & (d_s != 33'd0);
      d_ge_w = ($signed(d_s) >= $signed(w_s));
   end

   // Shared divider
   logic              div_start;
   logic [DIV_NW-1:0] div_num, div_den;
   logic              div_done;
   logic [7:0]        div_q;

   splc_div8 u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   // Segment capture during the scan
   logic [NCH-1:0][15:0]     l0_ff, l1_ff, b0_ff, b1_ff;
   logic [NCH-1:0]           stop_ff;
   logic [NCH-1:0][CNT_W-1:0] ncl;
   logic [15:0]              g16;

   assign g16 = {gray_ff, 8'd0};

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (cnt_ff[c] < 7'd2) begin
            ncl[c] = 7'd2;
         end else if (cnt_ff[c] > CNT_W'(MAX_POINTS)) begin
            ncl[c] = CNT_W'(MAX_POINTS);
         end else begin
            ncl[c] = cnt_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GDIV || state_ff == ST_GPRE) begin
         stop_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         for (int c = 0; c < NCH; c++) begin
            if (({1'b0, k_ff} <= (ncl[c] - 7'd2)) &&
                ((k_ff == '0) || !(stop_ff[c] || (cell_pt[0].level[c] > g16)))) begin
               l0_ff[c] <= cell_pt[0].level[c];
               b0_ff[c] <= cell_pt[0].bright[c];
               l1_ff[c] <= cell_pt[1].level[c];
               b1_ff[c] <= cell_pt[1].bright[c];
            end
            if (cell_pt[0].level[c] > g16) begin
               stop_ff[c] <= 1'b1;
            end
         end
      end
   end

   // Channel arithmetic on the selected segment
   logic [15:0]        sl0, sl1, sb0, sb1;
   logic signed [16:0] den_s, bd_s, gl_s;
   logic signed [33:0] p1_ff, p2_ff;
   logic signed [16:0] den_ff;
   logic [7:0]         b0hi_ff;
   logic signed [34:0] num_s;
   logic [34:0]        mag_num;
   logic [16:0]        mag_den;
   logic [31:0]        mag_d256;
   logic               sign_diff;

   always_comb begin
      case (ch_ff)
         2'd1: begin
            sl0 = l0_ff[1]; sl1 = l1_ff[1]; sb0 = b0_ff[1]; sb1 = b1_ff[1];
         end
         2'd2: begin
            sl0 = l0_ff[2]; sl1 = l1_ff[2]; sb0 = b0_ff[2]; sb1 = b1_ff[2];
         end
         default: begin
            sl0 = l0_ff[0]; sl1 = l1_ff[0]; sb0 = b0_ff[0]; sb1 = b1_ff[0];
         end
      endcase
      den_s = $signed({1'b0, sl1}) - $signed({1'b0, sl0});
      bd_s  = $signed({1'b0, sb1}) - $signed({1'b0, sb0});
      gl_s  = $signed({1'b0, g16}) - $signed({1'b0, sl0});
   end

   // Products registered before the sum
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         p1_ff   <= $signed({1'b0, sb0}) * den_s;
         p2_ff   <= bd_s * gl_s;
         den_ff  <= den_s;
         b0hi_ff <= sb0[15:8];
      end
   end

   always_comb begin
      num_s     = 35'(p1_ff) + 35'(p2_ff);
      mag_num   = num_s[34] ? 35'(-num_s) : 35'(num_s);
      mag_den   = den_ff[16] ? 17'(-den_ff) : 17'(den_ff);
      mag_d256  = {7'd0, mag_den, 8'd0};
      sign_diff = (num_s != 35'sd0) && (num_s[34] != den_ff[16]);
   end

   // Result registers
   logic [NCH-1:0][7:0] res_ff;
   logic [7:0]          rsp_gray_ff, rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                ch_wr;
   logic [7:0]          ch_val;
   logic [7:0]          ch_fin;

   always_comb begin
      ch_wr  = 1'b0;
      ch_val = 8'd0;
      if (state_ff == ST_SUM) begin
         if (den_ff == 17'sd0) begin
            ch_wr  = 1'b1;
            ch_val = b0hi_ff;
         end else if (sign_diff) begin
            ch_wr  = 1'b1;
            ch_val = 8'd0;
         end else if ({3'd0, mag_num} >= {mag_d256, 6'd0} + {mag_d256, 6'd0}
                                        + {mag_d256, 6'd0} + {mag_d256, 6'd0}) begin
            ch_wr  = 1'b1;
            ch_val = 8'd255;
         end
      end else if (state_ff == ST_CDIV && div_done) begin
         ch_wr  = 1'b1;
         ch_val = div_q;
      end
      ch_fin = invert_ff ? ~ch_val : ch_val;
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      if (state_ff == ST_GPRE) begin
         div_start = w_pos & d_pos & ~d_ge_w;
         div_num   = ({8'd0, d_s} << 8) - {8'd0, d_s};
         div_den   = {8'd0, w_s};
      end else if (state_ff == ST_SUM) begin
         div_start = ~ch_wr;
         div_num   = {6'd0, mag_num};
         div_den   = {9'd0, mag_d256};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_cmd == CMD_PIXEL) begin
               state_in = ST_GPRE;
            end
         end
         ST_GPRE: begin
            state_in = div_start ? ST_GDIV : ST_SCAN;
         end
         ST_GDIV: begin
            if (div_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (k_ff == IDX_W'(MAX_POINTS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM, ST_CDIV: begin
            if (ch_wr) begin
               state_in = (ch_ff == 2'd2) ? ST_OUT : ST_MUL;
            end else if (state_ff == ST_SUM) begin
               state_in = ST_CDIV;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         ch_ff        <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SCAN) begin
            k_ff <= k_ff + IDX_W'(1);
         end else begin
            k_ff <= '0;
         end
         if (state_ff == ST_SCAN) begin
            ch_ff <= 2'd0;
         end else if (ch_wr) begin
            ch_ff <= ch_ff + 2'd1;
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
      end
      if (state_ff == ST_GPRE) begin
         if (!w_pos || !d_pos) begin
            gray_ff <= 8'd0;
         end else if (d_ge_w) begin
            gray_ff <= 8'd255;
         end
      end else if (state_ff == ST_GDIV && div_done) begin
         gray_ff <= div_q;
      end
      if (ch_wr) begin
         res_ff[ch_ff] <= ch_fin;
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_gray_ff  <= gray_ff;
         rsp_red_ff   <= res_ff[0];
         rsp_green_ff <= res_ff[1];
         rsp_blue_ff  <= res_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gray  = rsp_gray_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule
`default_nettype wire

### bench/colormap_csr_pkg.sv
package colormap_csr_pkg;

   // Register indexes, one 32-bit word each
   localparam int REG_BLACK  = 0;
   localparam int REG_WHITE  = 1;
   localparam int REG_RED_N  = 2;
   localparam int REG_GRN_N  = 3;
   localparam int REG_BLU_N  = 4;
   localparam int REG_INVERT = 5;

   // Request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Channel codes; the fourth code is a load that must be dropped
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_NONE  = 2'd3;

endpackage

### bench/colormap_checker.sv
module colormap_checker
   import splc_pkg::*;
   import colormap_csr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_channel,
   input  logic [5:0]  req_point_index,
   input  logic [15:0] req_level,
   input  logic [15:0] req_brightness,
   input  logic [31:0] req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_gray,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);

   typedef struct {
      logic [7:0] gray;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   color_type colors_due[$];

   // Shadow configuration and control point stores
   longint     black_q = 65536;
   longint     white_q = 131072;
   logic [6:0] count_q [0:NCH-1] = '{7'd2, 7'd2, 7'd2};
   logic       invert_q = 1'b0;
   logic [15:0] level_mem  [0:NCH*MAX_POINTS-1];
   logic [15:0] bright_mem [0:NCH*MAX_POINTS-1];

   initial mismatches = 0;
   assign pending = colors_due.size();

   function automatic logic [7:0] scale_gray(logic [31:0] sample);
      longint d, w, g;
      d = longint'($signed(sample)) - black_q;
      w = white_q - black_q;
      if (w <= 0) return 8'd0;
      g = (255 * d) / w;
      if (g < 0) g = 0;
      if (g > 255) g = 255;
      return g[7:0];
   endfunction

   function automatic logic [7:0] map_channel(int ch, logic [7:0] gray);
      int n, base, i, seg;
      longint gl, l0, l1, b0, b1, den, v;
      n = count_q[ch];
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      base = ch * MAX_POINTS;
      gl = longint'(gray) * 256;
      for (i = 0; i < n; i++) begin
         if (longint'(level_mem[base+i]) > gl) break;
      end
      seg = i - 1;
      if (seg > n - 2) seg = n - 2;
      if (seg < 0) seg = 0;
      l0 = level_mem[base+seg];
      l1 = level_mem[base+seg+1];
      b0 = bright_mem[base+seg];
      b1 = bright_mem[base+seg+1];
      den = l1 - l0;
      if (den == 0) v = b0 / 256;
      else v = (b0 * den + (b1 - b0) * (gl - l0)) / (den * 256);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      if (invert_q) v = 255 - v;
      return v[7:0];
   endfunction

   task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sample all channels mid-cycle; inputs only move at the rising edge
   always @(negedge clock) begin
      color_type c;
      if (!reset) begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (int'(paddr >> 2))
               REG_BLACK:  black_q = longint'($signed(pwdata));
               REG_WHITE:  white_q = longint'($signed(pwdata));
               REG_RED_N:  count_q[0] = pwdata[6:0];
               REG_GRN_N:  count_q[1] = pwdata[6:0];
               REG_BLU_N:  count_q[2] = pwdata[6:0];
               REG_INVERT: invert_q = pwdata[0];
               default: ;
            endcase
         end
         // Apply a request transfer
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_LOAD) begin
               if (req_channel != CH_NONE) begin
                  level_mem[req_channel*MAX_POINTS + req_point_index]  = req_level;
                  bright_mem[req_channel*MAX_POINTS + req_point_index] = req_brightness;
               end
            end else begin
               c.gray  = scale_gray(req_sample);
               c.red   = map_channel(0, c.gray);
               c.green = map_channel(1, c.gray);
               c.blue  = map_channel(2, c.gray);
               colors_due.push_back(c);
            end
         end
         // Check a result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (colors_due.size() == 0) begin
               $display("%0t unexpected result: gray %0d red %0d green %0d blue %0d",
                        $time, rsp_gray, rsp_red, rsp_green, rsp_blue);
               mismatches++;
            end else begin
               c = colors_due.pop_front();
               compare_field("gray", c.gray, rsp_gray);
               compare_field("red", c.red, rsp_red);
               compare_field("green", c.green, rsp_green);
               compare_field("blue", c.blue, rsp_blue);
            end
         end
      end
   end

endmodule

### bench/scaled_piecewise_linear_colormap_top_test.sv
module scaled_piecewise_linear_colormap_top_test;
   import splc_pkg::*;
   import colormap_csr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_LOAD;
   logic [1:0]  req_channel = CH_RED;
   logic [5:0]  req_point_index = '0;
   logic [15:0] req_level = '0;
   logic [15:0] req_brightness = '0;
   logic [31:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_gray, rsp_red, rsp_green, rsp_blue;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          mismatches, pending;
   int          cycles = 0;
   int          burst_left = 0;
   longint      black_cur = 65536;
   longint      white_cur = 131072;

   scaled_piecewise_linear_colormap_top dut (.*);

   colormap_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stall pattern: free running, random, or long holds
   int stall_hold = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      case ((cycles / 500) % 3)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 40);
         default: begin
            if (stall_hold == 0) begin
               stall_hold = $urandom_range(1, 40);
               rsp_stall <= ~rsp_stall;
            end else begin
               stall_hold--;
            end
         end
      endcase
   end

   // Guard against a hung run
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Drive one request transfer, with random gaps between bursts
   task automatic send(logic cmd, logic [1:0] ch, logic [5:0] idx, logic [15:0] lvl,
                       logic [15:0] brt, logic [31:0] smp);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_channel     <= ch;
      req_point_index <= idx;
      req_level       <= lvl;
      req_brightness  <= brt;
      req_sample      <= smp;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      burst_left--;
   endtask

   task automatic load_point(logic [1:0] ch, logic [5:0] idx, logic [15:0] lvl,
                             logic [15:0] brt);
      send(CMD_LOAD, ch, idx, lvl, brt, $urandom);
   endtask

   task automatic pixel(logic [31:0] smp);
      send(CMD_PIXEL, 2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom), smp);
   endtask

   // Pixel sample mostly spread over the black..white span
   function automatic logic [31:0] pick_sample();
      longint w;
      w = white_cur - black_cur;
      if (w <= 0 || $urandom_range(0, 3) == 0) return $urandom;
      return 32'(black_cur + (w * $urandom_range(0, 300)) / 280 - w / 20
                 + $urandom_range(0, 3));
   endfunction

   // Hold off until every result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(int reg_idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(reg_idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      forever begin
         @(negedge clock);
         if (pready) break;
      end
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] blk, logic [31:0] wht, logic [6:0] nr,
                            logic [6:0] ng, logic [6:0] nb, logic inv);
      drain();
      csr_write(REG_BLACK, blk);
      csr_write(REG_WHITE, wht);
      csr_write(REG_RED_N, 32'(nr));
      csr_write(REG_GRN_N, 32'(ng));
      csr_write(REG_BLU_N, 32'(nb));
      csr_write(REG_INVERT, 32'(inv));
      black_cur = longint'($signed(blk));
      white_cur = longint'($signed(wht));
   endtask

   initial begin
      int ch, k, step;
      logic [15:0] lvl;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: red full ramp, green zero-width segment, blue falling levels
      load_point(CH_RED, 6'd0, 16'h0000, 16'h0000);
      load_point(CH_RED, 6'd1, 16'hFFFF, 16'hFFFF);
      load_point(CH_GREEN, 6'd0, 16'd1000, 16'hFFFF);
      load_point(CH_GREEN, 6'd1, 16'd1000, 16'h0000);
      load_point(CH_BLUE, 6'd0, 16'd40000, 16'h0000);
      load_point(CH_BLUE, 6'd1, 16'd20000, 16'hFFFF);
      load_point(CH_NONE, 6'd63, 16'hFFFF, 16'hFFFF);
      pixel(32'd65536);
      pixel(32'd131072);
      pixel(32'd98304);
      pixel(32'h8000_0000);
      pixel(32'h7FFF_FFFF);
      pixel(32'd65537);
      pixel(32'd131071);
      configure(32'd65536, 32'd65536, 7'd2, 7'd2, 7'd2, 1'b1);
      pixel(32'd70000);
      pixel(32'h7FFF_FFFF);

      // Fill every control point: mostly rising ramps, some scrambled
      configure(32'd0, 32'(255 << 16), 7'd2, 7'd2, 7'd2, 1'b0);
      for (ch = 0; ch < NCH; ch++) begin
         lvl = 16'($urandom_range(0, 600));
         for (k = 0; k < MAX_POINTS; k++) begin
            if ($urandom_range(0, 3) != 0) begin
               load_point(2'(ch), 6'(k), lvl, 16'($urandom));
               step = $urandom_range(0, 1400);
               lvl = (int'(lvl) + step > 65535) ? 16'hFFFF : 16'(int'(lvl) + step);
            end else begin
               load_point(2'(ch), 6'(k), 16'($urandom), 16'($urandom));
            end
         end
      end

      // Phases across register settings, pixels with occasional reloads
      for (k = 0; k < 6; k++) begin
         case (k)
            0: configure(32'd0, 32'(255 << 16), 7'd64, 7'd64, 7'd64, 1'b0);
            1: configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd2, 7'd33, 7'd64, 1'b1);
            2: configure(32'(100 << 16), 32'(100 << 16), 7'd64, 7'd0, 7'd127, 1'b0);
            3: configure(32'(5 << 16), 32'hFFFD_0000, 7'd10, 7'd64, 7'd2, 1'b1);
            4: configure(32'hFFF0_0000, 32'h0040_0000, 7'($urandom_range(2, 64)),
                         7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)),
                         1'($urandom));
            default: configure($urandom, $urandom, 7'($urandom), 7'($urandom),
                               7'($urandom), 1'($urandom));
         endcase
         repeat (58) begin
            if ($urandom_range(0, 4) == 0)
               load_point(2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
            else
               pixel(pick_sample());
         end
      end

      // Wait out the tail, then give the verdict
      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
design/splc_pkg.sv
design/splc_cell.sv
design/splc_div8.sv
design/scaled_piecewise_linear_colormap_top.sv
bench/colormap_csr_pkg.sv
bench/colormap_checker.sv
bench/scaled_piecewise_linear_colormap_top_test.sv
